// ===== hw/rtl/owtr_pkg.sv =====
// package for the one-wire temperature reader
// holds timing register types, reset values, phase and stage codes and result struct
// no dependencies
package owtr_pkg;

    // width of the conversion wait register, widest configuration register
    localparam int CONV_W = 20;
    // width of the short slot timing registers
    localparam int SLOT_W = 10;
    // default tick counter width
    localparam int WAIT_COUNTER_WIDTH_DEF = 20;

    // configuration register reset values
    localparam logic [SLOT_W-1:0] RESET_LOW_DEF       = SLOT_W'(485);
    localparam logic [SLOT_W-1:0] PRESENCE_SAMPLE_DEF = SLOT_W'(65);
    localparam logic [SLOT_W-1:0] RESET_RECOVER_DEF   = SLOT_W'(420);
    localparam logic [SLOT_W-1:0] SLOT_LOW_DEF        = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] WRITE_SLOT_DEF      = SLOT_W'(65);
    localparam logic [SLOT_W-1:0] READ_SAMPLE_DEF     = SLOT_W'(13);
    localparam logic [SLOT_W-1:0] READ_TAIL_DEF       = SLOT_W'(45);
    localparam logic [CONV_W-1:0] CONVERT_WAIT_DEF    = CONV_W'(750000);

    // one-wire command bytes, sent lsb first
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_RESET_LOW       = 3'd0,
        REG_PRESENCE_SAMPLE = 3'd1,
        REG_RESET_RECOVER   = 3'd2,
        REG_SLOT_LOW        = 3'd3,
        REG_WRITE_SLOT      = 3'd4,
        REG_READ_SAMPLE     = 3'd5,
        REG_READ_TAIL       = 3'd6,
        REG_CONVERT_WAIT    = 3'd7
    } reg_index_t;

    // stages of one read sequence
    typedef enum logic [2:0] {
        STG_RESET1    = 3'd0,
        STG_SKIP1     = 3'd1,
        STG_CONVERT   = 3'd2,
        STG_CONV_WAIT = 3'd3,
        STG_RESET2    = 3'd4,
        STG_SKIP2     = 3'd5,
        STG_READ_CMD  = 3'd6,
        STG_READ      = 3'd7
    } stage_t;

    // bus phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HOLD  = 4'd5,
        PH_CONV     = 4'd6,
        PH_RD_LOW   = 4'd7,
        PH_RD_WAIT  = 4'd8,
        PH_RD_TAIL  = 4'd9
    } phase_t;

    typedef struct packed {
        logic [SLOT_W-1:0] reset_low;
        logic [SLOT_W-1:0] presence_sample;
        logic [SLOT_W-1:0] reset_recover;
        logic [SLOT_W-1:0] slot_low;
        logic [SLOT_W-1:0] write_slot;
        logic [SLOT_W-1:0] read_sample;
        logic [SLOT_W-1:0] read_tail;
        logic [CONV_W-1:0] convert_wait;
    } timing_t;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               device_present;
        logic signed [15:0] temperature_raw;
    } result_t;

endpackage

// ===== hw/rtl/owtr_cfg_regs.sv =====
// timing configuration registers of the one-wire temperature reader
// depends on owtr_pkg
module owtr_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [owtr_pkg::CONV_W-1:0]  cfg_data,
    output owtr_pkg::timing_t            timing
);

    owtr_pkg::timing_t timing_reg;
    owtr_pkg::timing_t timing_next;

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_we)
        begin
            unique case (owtr_pkg::reg_index_t'(cfg_index))
                owtr_pkg::REG_RESET_LOW:
                    timing_next.reset_low = cfg_data[owtr_pkg::SLOT_W-1:0];
                owtr_pkg::REG_PRESENCE_SAMPLE:
                    timing_next.presence_sample = cfg_data[owtr_pkg::SLOT_W-1:0];
                owtr_pkg::REG_RESET_RECOVER:
                    timing_next.reset_recover = cfg_data[owtr_pkg::SLOT_W-1:0];
                owtr_pkg::REG_SLOT_LOW:
                    timing_next.slot_low = cfg_data[owtr_pkg::SLOT_W-1:0];
                owtr_pkg::REG_WRITE_SLOT:
                    timing_next.write_slot = cfg_data[owtr_pkg::SLOT_W-1:0];
                owtr_pkg::REG_READ_SAMPLE:
                    timing_next.read_sample = cfg_data[owtr_pkg::SLOT_W-1:0];
                owtr_pkg::REG_READ_TAIL:
                    timing_next.read_tail = cfg_data[owtr_pkg::SLOT_W-1:0];
                owtr_pkg::REG_CONVERT_WAIT:
                    timing_next.convert_wait = cfg_data;
                default:
                    timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low       <= owtr_pkg::RESET_LOW_DEF;
            timing_reg.presence_sample <= owtr_pkg::PRESENCE_SAMPLE_DEF;
            timing_reg.reset_recover   <= owtr_pkg::RESET_RECOVER_DEF;
            timing_reg.slot_low        <= owtr_pkg::SLOT_LOW_DEF;
            timing_reg.write_slot      <= owtr_pkg::WRITE_SLOT_DEF;
            timing_reg.read_sample     <= owtr_pkg::READ_SAMPLE_DEF;
            timing_reg.read_tail       <= owtr_pkg::READ_TAIL_DEF;
            timing_reg.convert_wait    <= owtr_pkg::CONVERT_WAIT_DEF;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    assign timing = timing_reg;

endmodule

// ===== hw/rtl/owtr_seq.sv =====
// bus sequencer of the one-wire temperature reader: phase, tick counter,
// command shifter and result words, stepped once per advanced tick item
// depends on owtr_pkg
module owtr_seq
#(
    parameter int WAIT_COUNTER_WIDTH = owtr_pkg::WAIT_COUNTER_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              start_request,
    input  logic              bus_level,
    input  owtr_pkg::timing_t timing,
    output owtr_pkg::result_t res
);

    localparam int W     = WAIT_COUNTER_WIDTH;
    localparam int LIM_W = (W > owtr_pkg::CONV_W) ? W : owtr_pkg::CONV_W;
    localparam logic [LIM_W-1:0] CNT_MAX = LIM_W'({W{1'b1}});

    owtr_pkg::phase_t phase_reg, phase_next;
    owtr_pkg::stage_t cmd_reg, cmd_next;
    logic [W-1:0]     tick_reg, tick_next;
    logic [3:0]       bit_reg, bit_next;
    logic [15:0]      shift_reg, shift_next;
    logic             present_reg, present_next;
    logic [15:0]      temp_reg, temp_next;

    owtr_pkg::phase_t eff_phase;
    owtr_pkg::stage_t eff_cmd;
    logic [W-1:0]     eff_tick;
    logic [3:0]       eff_bit;
    logic [LIM_W-1:0] lim_raw;
    logic [LIM_W-1:0] lim;
    logic [W-1:0]     tick_inc;
    logic             tend;
    logic             enter;
    owtr_pkg::stage_t enter_idx;
    logic             drive;
    logic             busy;
    logic             done;

    // wait limit of the current phase, clipped to what the counter can hold
    always_comb
    begin
        eff_phase = phase_reg;
        eff_cmd   = cmd_reg;
        eff_tick  = tick_reg;
        eff_bit   = bit_reg;
        if (phase_reg == owtr_pkg::PH_IDLE && start_request)
        begin
            eff_phase = owtr_pkg::PH_RST_LOW;
            eff_cmd   = owtr_pkg::STG_RESET1;
            eff_tick  = '0;
            eff_bit   = '0;
        end
        case (eff_phase)
            owtr_pkg::PH_RST_LOW:  lim_raw = LIM_W'(timing.reset_low);
            owtr_pkg::PH_RST_WAIT: lim_raw = LIM_W'(timing.presence_sample);
            owtr_pkg::PH_RST_REC:  lim_raw = LIM_W'(timing.reset_recover);
            owtr_pkg::PH_WR_HOLD:  lim_raw = LIM_W'(timing.write_slot);
            owtr_pkg::PH_CONV:     lim_raw = LIM_W'(timing.convert_wait);
            owtr_pkg::PH_RD_WAIT:  lim_raw = LIM_W'(timing.read_sample);
            owtr_pkg::PH_RD_TAIL:  lim_raw = LIM_W'(timing.read_tail);
            default:               lim_raw = LIM_W'(timing.slot_low);
        endcase
        lim      = (lim_raw > CNT_MAX) ? CNT_MAX : lim_raw;
        tick_inc = eff_tick + W'(1);
        // a zero limit ends the phase at once, as does counter wrap
        tend     = (tick_inc == '0) || (LIM_W'(tick_inc) >= lim);
    end

    always_comb
    begin
        phase_next   = eff_phase;
        cmd_next     = eff_cmd;
        bit_next     = eff_bit;
        shift_next   = shift_reg;
        present_next = present_reg;
        temp_next    = temp_reg;
        tick_next    = tend ? '0 : tick_inc;
        enter        = 1'b0;
        enter_idx    = owtr_pkg::stage_t'(eff_cmd + 3'd1);
        drive        = 1'b0;
        busy         = 1'b1;
        done         = 1'b0;

        unique case (eff_phase)
            owtr_pkg::PH_IDLE:
            begin
                busy      = 1'b0;
                tick_next = tick_reg;
            end
            owtr_pkg::PH_RST_LOW:
            begin
                drive = 1'b1;
                if (tend)
                    phase_next = owtr_pkg::PH_RST_WAIT;
            end
            owtr_pkg::PH_RST_WAIT:
            begin
                if (tend)
                    phase_next = owtr_pkg::PH_RST_REC;
            end
            owtr_pkg::PH_RST_REC:
            begin
                // presence sample only in the first reset
                if (eff_tick == '0 && eff_cmd == owtr_pkg::STG_RESET1)
                    present_next = ~bus_level;
                if (tend)
                begin
                    if (eff_cmd == owtr_pkg::STG_RESET1 && !present_next)
                    begin
                        temp_next  = '0;
                        phase_next = owtr_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        enter = 1'b1;
                    end
                end
            end
            owtr_pkg::PH_WR_LOW:
            begin
                drive = 1'b1;
                if (tend)
                    phase_next = owtr_pkg::PH_WR_HOLD;
            end
            owtr_pkg::PH_WR_HOLD:
            begin
                drive = ~shift_reg[eff_bit[2:0]];
                if (tend)
                begin
                    if (eff_bit >= 4'd7)
                    begin
                        enter = 1'b1;
                    end
                    else
                    begin
                        bit_next   = eff_bit + 4'd1;
                        phase_next = owtr_pkg::PH_WR_LOW;
                    end
                end
            end
            owtr_pkg::PH_CONV:
            begin
                if (tend)
                    enter = 1'b1;
            end
            owtr_pkg::PH_RD_LOW:
            begin
                drive = 1'b1;
                if (tend)
                    phase_next = owtr_pkg::PH_RD_WAIT;
            end
            owtr_pkg::PH_RD_WAIT:
            begin
                if (tend)
                    phase_next = owtr_pkg::PH_RD_TAIL;
            end
            owtr_pkg::PH_RD_TAIL:
            begin
                if (eff_tick == '0 && bus_level)
                    shift_next[eff_bit] = 1'b1;
                if (tend)
                begin
                    if (eff_bit >= 4'd15)
                    begin
                        temp_next  = shift_next;
                        phase_next = owtr_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        bit_next   = eff_bit + 4'd1;
                        phase_next = owtr_pkg::PH_RD_LOW;
                    end
                end
            end
            default:
            begin
                phase_next = owtr_pkg::PH_IDLE;
                busy       = 1'b0;
                tick_next  = tick_reg;
            end
        endcase

        // move on to the next stage of the sequence
        if (enter)
        begin
            cmd_next  = enter_idx;
            bit_next  = '0;
            tick_next = '0;
            unique case (enter_idx)
                owtr_pkg::STG_RESET1, owtr_pkg::STG_RESET2:
                    phase_next = owtr_pkg::PH_RST_LOW;
                owtr_pkg::STG_SKIP1, owtr_pkg::STG_SKIP2:
                begin
                    phase_next = owtr_pkg::PH_WR_LOW;
                    shift_next = {8'h00, owtr_pkg::CMD_SKIP_ROM};
                end
                owtr_pkg::STG_CONVERT:
                begin
                    phase_next = owtr_pkg::PH_WR_LOW;
                    shift_next = {8'h00, owtr_pkg::CMD_CONVERT};
                end
                owtr_pkg::STG_CONV_WAIT:
                    phase_next = owtr_pkg::PH_CONV;
                owtr_pkg::STG_READ_CMD:
                begin
                    phase_next = owtr_pkg::PH_WR_LOW;
                    shift_next = {8'h00, owtr_pkg::CMD_READ_PAD};
                end
                default:
                begin
                    phase_next = owtr_pkg::PH_RD_LOW;
                    shift_next = '0;
                end
            endcase
        end

        res.drive_low       = drive;
        res.busy_res        = busy;
        res.done_res        = done;
        res.device_present  = present_next;
        res.temperature_raw = temp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= owtr_pkg::PH_IDLE;
            cmd_reg     <= owtr_pkg::STG_RESET1;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            present_reg <= 1'b0;
            temp_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            present_reg <= present_next;
            temp_reg    <= temp_next;
        end
    end

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.done_res |=> phase_reg == owtr_pkg::PH_IDLE)
        else $error("sequence end did not return to idle");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(tick_reg) && $stable(shift_reg))
        else $error("sequencer state moved without an advanced item");

    a_write_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == owtr_pkg::PH_WR_LOW || phase_reg == owtr_pkg::PH_WR_HOLD)
        |-> bit_reg <= 4'd7)
        else $error("write slot bit index beyond one byte");

    a_conv_stage: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == owtr_pkg::PH_CONV |-> cmd_reg == owtr_pkg::STG_CONV_WAIT)
        else $error("conversion wait outside its stage");

    a_present_kept: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd_reg != owtr_pkg::STG_RESET1 && phase_reg != owtr_pkg::PH_IDLE
        |=> $stable(present_reg))
        else $error("presence flag changed outside the first reset");

endmodule

// ===== hw/rtl/one_wire_temperature_reader.sv =====
// one-wire temperature reader: one tick item in, one bus/result item out
// each tick item passes through the input register and then the result register
// throughput one tick item per cycle while the result side does not stall; the sequencer steps once per item
// asynchronous active-low reset: idle, timing registers at their defaults, sequencer results zero
// depends on owtr_pkg, owtr_cfg_regs, owtr_seq
module one_wire_temperature_reader
#(
    // width of the phase tick counter; longer waits are clipped to its range
    parameter int WAIT_COUNTER_WIDTH = owtr_pkg::WAIT_COUNTER_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // tick items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] start_request, [1] bus_level
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [0] drive_low, [1] busy_res,
                                                   // [2] device_present, [18:3] temperature_raw
    output logic                        m_tlast,   // done_res, last tick of a sequence
    // timing register writes
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [owtr_pkg::CONV_W-1:0] cfg_data
);

    // input register stage
    logic in_valid_reg, in_valid_next;
    logic in_start_reg;
    logic in_level_reg;

    // result register stage
    logic              out_valid_reg, out_valid_next;
    owtr_pkg::result_t out_res_reg;

    owtr_pkg::timing_t timing;
    owtr_pkg::result_t res;
    logic              advance;

    // the held tick item moves on whenever the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
            in_valid_next = 1'b0;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_start_reg <= s_tdata[0];
            in_level_reg <= s_tdata[1];
        end
        if (advance)
            out_res_reg <= res;
    end

    owtr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    owtr_seq
    #(
        .WAIT_COUNTER_WIDTH (WAIT_COUNTER_WIDTH)
    )
    u_seq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .start_request (in_start_reg),
        .bus_level     (in_level_reg),
        .timing        (timing),
        .res           (res)
    );

    // pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.done_res;
    assign m_tdata  = {5'd0,
                       out_res_reg.temperature_raw,
                       out_res_reg.device_present,
                       out_res_reg.busy_res,
                       out_res_reg.drive_low};

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for the one-wire temperature reader: tick items in, bus/result items out
// predicts every result tick from its own bus master model and plays the device on the line
// depends on owtr_pkg and one_wire_temperature_reader
module tb_top;
    import owtr_pkg::*;

    // generous cycle ceiling: the run is about 750 ticks, each with random gaps and stalls,
    // plus one long receiver hold and the drains around register writes
    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int          HOLD_CYCLES = 200;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;      // [0] start_request, [1] bus_level
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;           // [0] drive_low, [1] busy_res,
                                            // [2] device_present, [18:3] temperature_raw
    logic                m_tlast;           // done_res
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [CONV_W-1:0]   cfg_data = '0;

    // bench bookkeeping
    result_t             pending_bus_results[$];
    int unsigned         cycle_count = 0;
    int unsigned         error_count = 0;
    int unsigned         ticks_sent = 0;
    int unsigned         results_checked = 0;
    int unsigned         reads_done = 0;
    int unsigned         reads_present = 0;
    bit                  tx_gaps_on = 1'b1;
    bit                  rx_gaps_on = 1'b1;
    int                  rx_hold_len = 0;

    // bus master model state, mirrors the block after reset
    phase_t              bus_phase = PH_IDLE;
    stage_t              seq_stage = STG_RESET1;
    logic [19:0]         span_count = '0;
    logic [3:0]          bit_pos = '0;
    logic [15:0]         shift_reg = '0;
    logic                present_seen = 1'b0;
    logic [15:0]         temp_word = '0;
    timing_t             timing = '{RESET_LOW_DEF, PRESENCE_SAMPLE_DEF, RESET_RECOVER_DEF,
                                    SLOT_LOW_DEF, WRITE_SLOT_DEF, READ_SAMPLE_DEF,
                                    READ_TAIL_DEF, CONVERT_WAIT_DEF};

    one_wire_temperature_reader DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // bus master model
    // ---------------------------------------------------------------

    // counts one tick of the current phase; a zero span behaves as one tick
    function automatic bit count_span(input logic [19:0] span);
        logic [19:0] lim;
        lim = (span == '0) ? 20'd1 : span;
        span_count = span_count + 20'd1;
        if (span_count >= lim || span_count == '0)
        begin
            span_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void enter_stage(input stage_t s);
        seq_stage = s;
        bit_pos = '0;
        span_count = '0;
        case (s)
            STG_RESET1, STG_RESET2:
                bus_phase = PH_RST_LOW;
            STG_SKIP1, STG_SKIP2:
            begin
                bus_phase = PH_WR_LOW;
                shift_reg = {8'h00, CMD_SKIP_ROM};
            end
            STG_CONVERT:
            begin
                bus_phase = PH_WR_LOW;
                shift_reg = {8'h00, CMD_CONVERT};
            end
            STG_CONV_WAIT:
                bus_phase = PH_CONV;
            STG_READ_CMD:
            begin
                bus_phase = PH_WR_LOW;
                shift_reg = {8'h00, CMD_READ_PAD};
            end
            default:
            begin
                bus_phase = PH_RD_LOW;
                shift_reg = '0;
            end
        endcase
    endfunction

    // one tick of the bus master: what the block drives and reports for it
    function automatic void step_bus_master(input bit start, input bit level,
                                            output result_t res);
        res = '0;
        if (bus_phase == PH_IDLE && start)
            enter_stage(STG_RESET1);
        if (bus_phase != PH_IDLE)
        begin
            res.busy_res = 1'b1;
            case (bus_phase)
                PH_RST_LOW:
                begin
                    res.drive_low = 1'b1;
                    if (count_span(20'(timing.reset_low)))
                        bus_phase = PH_RST_WAIT;
                end
                PH_RST_WAIT:
                    if (count_span(20'(timing.presence_sample)))
                        bus_phase = PH_RST_REC;
                PH_RST_REC:
                begin
                    // only the first reset of a read takes the presence answer
                    if (span_count == '0 && seq_stage == STG_RESET1)
                        present_seen = !level;
                    if (count_span(20'(timing.reset_recover)))
                    begin
                        if (seq_stage == STG_RESET1 && !present_seen)
                        begin
                            temp_word = '0;
                            bus_phase = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                            enter_stage(stage_t'(seq_stage + 3'd1));
                    end
                end
                PH_WR_LOW:
                begin
                    res.drive_low = 1'b1;
                    if (count_span(20'(timing.slot_low)))
                        bus_phase = PH_WR_HOLD;
                end
                PH_WR_HOLD:
                begin
                    res.drive_low = !shift_reg[bit_pos[2:0]];
                    if (count_span(20'(timing.write_slot)))
                    begin
                        if (bit_pos >= 4'd7)
                            enter_stage(stage_t'(seq_stage + 3'd1));
                        else
                        begin
                            bit_pos = bit_pos + 4'd1;
                            bus_phase = PH_WR_LOW;
                        end
                    end
                end
                PH_CONV:
                    if (count_span(timing.convert_wait))
                        enter_stage(stage_t'(seq_stage + 3'd1));
                PH_RD_LOW:
                begin
                    res.drive_low = 1'b1;
                    if (count_span(20'(timing.slot_low)))
                        bus_phase = PH_RD_WAIT;
                end
                PH_RD_WAIT:
                    if (count_span(20'(timing.read_sample)))
                        bus_phase = PH_RD_TAIL;
                PH_RD_TAIL:
                begin
                    if (span_count == '0 && level)
                        shift_reg[bit_pos] = 1'b1;
                    if (count_span(20'(timing.read_tail)))
                    begin
                        if (bit_pos >= 4'd15)
                        begin
                            temp_word = shift_reg;
                            bus_phase = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            bit_pos = bit_pos + 4'd1;
                            bus_phase = PH_RD_LOW;
                        end
                    end
                end
                default:
                begin
                    bus_phase = PH_IDLE;
                    res.busy_res = 1'b0;
                end
            endcase
        end
        res.device_present = present_seen;
        res.temperature_raw = temp_word;
    endfunction

    // plays the sensor: answers the first presence sample and returns word lsb first
    // on read samples; everywhere else the line level is noise
    function automatic bit line_level(input bit answer, input logic [15:0] word);
        if (bus_phase == PH_RST_REC && span_count == '0 && seq_stage == STG_RESET1)
            return !answer;
        if (bus_phase == PH_RD_TAIL && span_count == '0)
            return word[bit_pos];
        return 1'($urandom);
    endfunction

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bus_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result transfer, expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_bus_results.pop_front();
                check_field("drive_low", want.drive_low, m_tdata[0]);
                check_field("busy_res", want.busy_res, m_tdata[1]);
                check_field("done_res", want.done_res, m_tlast);
                check_field("device_present", want.device_present, m_tdata[2]);
                check_field("temperature_raw", {16'd0, want.temperature_raw}, m_tdata[18:3]);
                results_checked++;
                if (m_tlast)
                begin
                    reads_done++;
                    if (m_tdata[2])
                        reads_present++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: random stalls, or a long hold when a test asks for one
    // ---------------------------------------------------------------

    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                stall = rx_gaps_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one tick transfer; valid stays up between back-to-back ticks
    task automatic send_tick(input bit start, input bit level, output result_t want);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, level, start};
        do @(posedge clk); while (!s_tready);
        step_bus_master(start, level, want);
        pending_bus_results.push_back(want);
        ticks_sent++;
    endtask

    // stop offering ticks and let every predicted result come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write; only called with the block idle and drained
    task automatic set_timing(input reg_index_t idx, input logic [CONV_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RESET_LOW:       timing.reset_low = value[SLOT_W-1:0];
            REG_PRESENCE_SAMPLE: timing.presence_sample = value[SLOT_W-1:0];
            REG_RESET_RECOVER:   timing.reset_recover = value[SLOT_W-1:0];
            REG_SLOT_LOW:        timing.slot_low = value[SLOT_W-1:0];
            REG_WRITE_SLOT:      timing.write_slot = value[SLOT_W-1:0];
            REG_READ_SAMPLE:     timing.read_sample = value[SLOT_W-1:0];
            REG_READ_TAIL:       timing.read_tail = value[SLOT_W-1:0];
            default:             timing.convert_wait = value;
        endcase
    endtask

    task automatic set_all_timing(input logic [19:0] rst_low, input logic [19:0] presence,
                                  input logic [19:0] recover, input logic [19:0] slot_low,
                                  input logic [19:0] write_hold, input logic [19:0] rd_sample,
                                  input logic [19:0] rd_tail, input logic [19:0] conv);
        wait_drained();
        set_timing(REG_RESET_LOW, rst_low);
        set_timing(REG_PRESENCE_SAMPLE, presence);
        set_timing(REG_RESET_RECOVER, recover);
        set_timing(REG_SLOT_LOW, slot_low);
        set_timing(REG_WRITE_SLOT, write_hold);
        set_timing(REG_READ_SAMPLE, rd_sample);
        set_timing(REG_READ_TAIL, rd_tail);
        set_timing(REG_CONVERT_WAIT, conv);
    endtask

    // short slot span with junk above the register width, sometimes zero
    function automatic logic [19:0] rnd_span();
        logic [9:0] span;
        span = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 2));
        return {10'($urandom), span};
    endfunction

    task automatic idle_ticks(input int count);
        result_t want;
        repeat (count) send_tick(1'b0, 1'($urandom), want);
    endtask

    // one full read from the idle state; follow=0 leaves every sample to noise,
    // hold_start keeps start high on every tick including the last one
    task automatic run_read(input bit answer, input logic [15:0] word, input bit follow,
                            input bit hold_start, input int hold_at, input int pause_at);
        result_t want;
        int n;
        bit start;
        n = 0;
        do
        begin
            start = (n == 0) || hold_start || ($urandom_range(0, 7) == 0);
            if (n == hold_at)
                rx_hold_len = HOLD_CYCLES;
            if (n == pause_at)
                wait_drained();
            send_tick(start, follow ? line_level(answer, word) : 1'($urandom), want);
            n++;
        end
        while (!want.done_res);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // ticks with no start after reset: outputs stay quiet
    task automatic test_idle_after_reset();
        idle_ticks(8);
    endtask

    // all spans at one tick, nobody answers the reset pulse
    task automatic test_fastest_timing();
        set_all_timing(1, 1, 1, 1, 1, 1, 1, 1);
        run_read(1'b0, 16'h1234, 1'b1, 1'b0, -1, -1);
    endtask

    // zero in every register behaves as a one-tick span; largest positive word
    task automatic test_zero_timing();
        set_all_timing(0, 0, 0, 0, 0, 0, 0, 0);
        run_read(1'b1, 16'h7FFF, 1'b1, 1'b0, -1, -1);
        run_read(1'b0, 16'h0000, 1'b1, 1'b0, -1, -1);
    endtask

    // start held high: ignored while busy and on the closing tick
    task automatic test_start_held();
        set_all_timing(1, 2, 1, 1, 2, 1, 2, 3);
        run_read(1'b0, 16'h0000, 1'b1, 1'b1, -1, -1);
        run_read(1'b1, 16'hFC90, 1'b1, 1'b1, -1, -1);
    endtask

    // receiver holds off while ticks keep coming, then the sender pauses mid read;
    // most negative word
    task automatic test_back_pressure();
        set_all_timing(1, 1, 1, 1, 1, 1, 1, 1);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_read(1'b1, 16'h8000, 1'b1, 1'b0, 20, 90);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // widest conversion wait written; an absent device never reaches it
    task automatic test_conversion_wait();
        set_all_timing(3, 2, 3, 1, 2, 2, 1, 20'hFFFFF);
        run_read(1'b0, 16'h0000, 1'b1, 1'b0, -1, -1);
        set_all_timing(1, 1, 1, 1, 1, 1, 1, 12);
        run_read(1'b1, 16'h00AA, 1'b1, 1'b0, -1, -1);
    endtask

    // mostly well-formed reads with random words and timings, some noise and no-shows
    task automatic test_random();
        int unsigned first_tick;
        int reads;
        first_tick = ticks_sent;
        reads = 0;
        while (ticks_sent - first_tick < 60 || reads < 1)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                set_all_timing(rnd_span(), rnd_span(), rnd_span(), rnd_span(), rnd_span(),
                               rnd_span(), rnd_span(), 20'($urandom_range(0, 8)));
            idle_ticks($urandom_range(0, 4));
            case ($urandom_range(0, 7))
                0:       run_read(1'b0, 16'($urandom), 1'b1, 1'b0, -1, -1);
                1:       run_read(1'b0, 16'h0000, 1'b0, 1'b0, -1, -1);
                2:       run_read(1'b1, 16'($urandom), 1'b1, 1'b1, -1, -1);
                default: run_read(1'b1, 16'($urandom), 1'b1, 1'b0, -1, -1);
            endcase
            reads++;
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // sequence of tests
    // ---------------------------------------------------------------

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_fastest_timing();
        test_zero_timing();
        test_start_held();
        test_back_pressure();
        test_conversion_wait();
        test_random();

        wait_drained();
        $display("tb_top: %0d ticks driven, %0d result transfers compared",
                 ticks_sent, results_checked);
        $display("tb_top: %0d reads finished, %0d with a device answering",
                 reads_done, reads_present);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
